// ----- rtl/core/dtnp_pkg.sv -----
// Shared types, constants and the fraction weight table of the decimal text parser.
`timescale 1ns / 1ps

package dtnp_pkg;

   // Character codes and limits.
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] SEPARATOR_RESET = 8'd46;
   localparam logic [31:0] DECIMAL_BASE = 32'd10;
   localparam logic [3:0] MAX_FRACTION_DIGITS = 4'd9;

   // Parse phases.
   typedef enum logic [1:0] {
      PH_SKIP,
      PH_INT,
      PH_FRAC,
      PH_STOP
   } phase_type;

   // One request: a character and its end-of-text flag.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   // One result: the parsed number.
   typedef struct packed {
      logic [31:0] integer_value;
      logic [31:0] fraction_q32;
      logic [3:0]  fraction_count;
      logic        digit_seen;
   } rsp_type;

   // Parser state carried from character to character.
   typedef struct packed {
      phase_type   phase;
      logic [31:0] integer_acc;
      logic [31:0] fraction_acc;
      logic [3:0]  fraction_digit_count;
      logic        any_digit;
   } parse_state_type;

   // Weight of the k-th fraction digit (k counted from zero): round(2^32 / 10^(k+1)).
   function automatic logic [31:0] frac_weight(input logic [3:0] k);
      logic [31:0] w;
      case (k)
         4'd0:    w = 32'd429496730;
         4'd1:    w = 32'd42949673;
         4'd2:    w = 32'd4294967;
         4'd3:    w = 32'd429497;
         4'd4:    w = 32'd42950;
         4'd5:    w = 32'd4295;
         4'd6:    w = 32'd429;
         4'd7:    w = 32'd43;
         4'd8:    w = 32'd4;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

   // State after reset and after every end of text.
   localparam parse_state_type STATE_CLEAR = '{
      phase: PH_SKIP,
      integer_acc: 32'd0,
      fraction_acc: 32'd0,
      fraction_digit_count: 4'd0,
      any_digit: 1'b0
   };

endpackage

// ----- rtl/core/dtnp_step.sv -----
// Per-character parse step: next parser state and the result for an end of text.
`timescale 1ns / 1ps

module dtnp_step
   import dtnp_pkg::*;
(
   input  req_type         req,
   input  logic [7:0]      separator,
   input  parse_state_type state_cur,
   output parse_state_type state_next,
   output rsp_type         rsp
);

   logic            is_digit;
   logic            is_sep;
   logic [3:0]      digit;
   logic [35:0]     frac_product;
   logic [36:0]     frac_sum;
   logic [31:0]     frac_sat;
   parse_state_type upd;

   // Classify the character.
   always_comb begin
      is_digit = req.char_code inside {[CHAR_ZERO:CHAR_NINE]};
      is_sep   = (req.char_code == separator);
      digit    = req.char_code[3:0];
   end

   // Fraction digit contribution, saturated at all ones.
   always_comb begin
      frac_product = {32'd0, digit} * {4'd0, frac_weight(state_cur.fraction_digit_count)};
      frac_sum     = {5'd0, state_cur.fraction_acc} + {1'b0, frac_product};
      frac_sat     = (frac_sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : frac_sum[31:0];
   end

   // Phase transitions and accumulation.
   always_comb begin
      upd = state_cur;
      case (state_cur.phase)
         PH_SKIP: begin
            if (is_digit) begin
               if (is_sep) begin
                  upd.phase = PH_FRAC;
               end else begin
                  upd.phase       = PH_INT;
                  upd.integer_acc = {28'd0, digit};
                  upd.any_digit   = 1'b1;
               end
            end
         end
         PH_INT: begin
            if (is_sep) begin
               upd.phase = PH_FRAC;
            end else if (is_digit) begin
               upd.integer_acc = 32'(state_cur.integer_acc * DECIMAL_BASE) + {28'd0, digit};
               upd.any_digit   = 1'b1;
            end else begin
               upd.phase = PH_STOP;
            end
         end
         PH_FRAC: begin
            if (is_sep) begin
               // A repeated separator changes nothing.
            end else if (is_digit) begin
               if (state_cur.fraction_digit_count < MAX_FRACTION_DIGITS) begin
                  upd.fraction_acc         = frac_sat;
                  upd.fraction_digit_count = state_cur.fraction_digit_count + 4'd1;
               end
               upd.any_digit = 1'b1;
            end else begin
               upd.phase = PH_STOP;
            end
         end
         default: begin
            // Stopped: ignore everything until the end of text.
         end
      endcase
   end

   // Result from the updated state; the state clears after the last character.
   always_comb begin
      if (upd.any_digit) begin
         rsp.integer_value  = upd.integer_acc;
         rsp.fraction_q32   = upd.fraction_acc;
         rsp.fraction_count = upd.fraction_digit_count;
         rsp.digit_seen     = 1'b1;
      end else begin
         rsp = '0;
      end
      state_next = req.end_of_text ? STATE_CLEAR : upd;
   end

endmodule

// ----- rtl/core/decimal_text_number_parser.sv -----
// Top level of the decimal text parser: request register, parser state and result register.
`timescale 1ns / 1ps

// Parses an unsigned decimal number from a character stream, one character per request, and
// returns one result per string on the character flagged end_of_text: the integer part modulo
// 2^32, the fraction as unsigned Q0.32 (saturating, at most nine digits), the fraction digit
// count and a digit-seen flag. Throughput is one character per clock cycle, except that a last
// character stalls while an untaken result blocks the result register. Each character passes
// through a request register, combinational parse logic whose longest path is the
// constant-weight multiply-add of a fraction digit, and the result register. The user must
// write the separator register through the csr_ port only while no request is in flight; the
// block itself does not enforce this. The separator register resets to the period character.
module decimal_text_number_parser
   import dtnp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic            req_valid_ff;
   req_type         req_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_type         rsp_in;
   logic [7:0]      separator_ff;
   logic            advance;

   // The held request moves on unless it owes a result and the result register is blocked.
   assign advance   = req_valid_ff &&
                      (!req_ff.end_of_text || !rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // Parse step on the held request.
   dtnp_step u_step (
      .req        (req_ff),
      .separator  (separator_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Result register valid: set by a finished string, cleared when taken.
   always_comb begin
      if (advance && req_ff.end_of_text) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state, parser state and separator register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
         separator_ff <= SEPARATOR_RESET;
      end else begin
         req_valid_ff <= req_valid || (req_valid_ff && !advance);
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            separator_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance && req_ff.end_of_text) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result without digits carries all zeros.
   a_no_digit_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.digit_seen) |->
         (rsp_ff.integer_value == 32'd0 && rsp_ff.fraction_q32 == 32'd0 &&
          rsp_ff.fraction_count == 4'd0))
      else $error("result without digits has nonzero fields");

   // The fraction digit count never passes its limit.
   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      (state_ff.fraction_digit_count <= MAX_FRACTION_DIGITS))
      else $error("fraction digit count beyond limit");

   // The parser state is clear after the end of a string.
   a_clear_after_end : assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.end_of_text) |=>
         (state_ff.phase == PH_SKIP && !state_ff.any_digit &&
          state_ff.fraction_digit_count == 4'd0))
      else $error("parser state not cleared after end of text");

   // A finished string never overwrites a result that has not been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.end_of_text) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// ----- sim/decimal_text_number_parser_tb.sv -----
// Self-checking testbench for the decimal text parser: strings, separator settings and stalls.
`timescale 1ns / 1ps

module decimal_text_number_parser_tb;
   import dtnp_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASE_CHARS = 180;
   localparam int PHASE_COUNT = 6;
   localparam int PRESSURE_PHASE = 2;
   localparam int SHOWN_ERRORS = 40;

   // Ways the result side paces its ready.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_MOSTLY
   } ready_pattern_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   // Characters waiting to be sent and numbers waiting to come back.
   req_type         outgoing_chars[$];
   rsp_type         pending_numbers[$];
   int              chars_queued = 0;
   parse_state_type parser_now = STATE_CLEAR;
   logic [7:0]      separator_now = SEPARATOR_RESET;
   logic [7:0]      separator_plan[PHASE_COUNT] =
      '{SEPARATOR_RESET, 8'h00, 8'hFF, 8'h35, 8'h2C, SEPARATOR_RESET};
   int              error_count = 0;
   int              idle_cycles = 0;
   logic            hold_request = 1'b0;

   // Sender and receiver pacing.
   int                burst_left = 0;
   int                gap_left = 0;
   int                hold_left = 0;
   logic              hold_started = 1'b0;
   ready_pattern_type ready_pattern = READY_ALWAYS;
   int                pattern_cycles = 0;

   always #1 clock = ~clock;

   decimal_text_number_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Weight of fraction digit k (counted from zero): round(2^32 / 10^(k+1)).
   function automatic logic [31:0] digit_weight(input logic [3:0] k);
      logic [63:0] scale;
      scale = 64'd1;
      for (int i = 0; i <= k; i++) begin
         scale = scale * 64'd10;
      end
      return 32'((((64'd1 << 33) / scale) + 64'd1) >> 1);
   endfunction

   // Advances the parser by one character and queues the number that a string end yields.
   function automatic void parse_char(input req_type item);
      logic        is_digit;
      logic        is_sep;
      logic [3:0]  digit;
      logic [32:0] sum;
      rsp_type     number;
      is_digit = item.char_code >= CHAR_ZERO && item.char_code <= CHAR_NINE;
      is_sep = item.char_code == separator_now;
      digit = 4'(item.char_code - CHAR_ZERO);
      case (parser_now.phase)
         PH_SKIP: begin
            // A separator that is also a digit opens the fraction without counting.
            if (is_digit && is_sep) begin
               parser_now.phase = PH_FRAC;
            end else if (is_digit) begin
               parser_now.phase = PH_INT;
               parser_now.integer_acc = 32'(digit);
               parser_now.any_digit = 1'b1;
            end
         end
         PH_INT: begin
            if (is_sep) begin
               parser_now.phase = PH_FRAC;
            end else if (is_digit) begin
               parser_now.integer_acc = parser_now.integer_acc * DECIMAL_BASE + 32'(digit);
               parser_now.any_digit = 1'b1;
            end else begin
               parser_now.phase = PH_STOP;
            end
         end
         PH_FRAC: begin
            // A repeated separator changes nothing; digits past the limit are dropped.
            if (is_digit && !is_sep) begin
               if (parser_now.fraction_digit_count < MAX_FRACTION_DIGITS) begin
                  sum = {1'b0, parser_now.fraction_acc}
                        + 33'(digit) * 33'(digit_weight(parser_now.fraction_digit_count));
                  parser_now.fraction_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  parser_now.fraction_digit_count = parser_now.fraction_digit_count + 4'd1;
               end
               parser_now.any_digit = 1'b1;
            end else if (!is_sep) begin
               parser_now.phase = PH_STOP;
            end
         end
         default: begin
         end
      endcase
      if (item.end_of_text) begin
         number = '0;
         if (parser_now.any_digit) begin
            number.integer_value = parser_now.integer_acc;
            number.fraction_q32 = parser_now.fraction_acc;
            number.fraction_count = parser_now.fraction_digit_count;
            number.digit_seen = 1'b1;
         end
         pending_numbers.push_back(number);
         parser_now = STATE_CLEAR;
      end
   endfunction

   function automatic void report_mismatch(input string field, input logic [31:0] want,
                                           input logic [31:0] got);
      if (error_count < SHOWN_ERRORS) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
      error_count++;
   endfunction

   // Compares one returned number with the oldest expected one.
   function automatic void check_number(input rsp_type got);
      rsp_type want;
      if (pending_numbers.size() == 0) begin
         if (error_count < SHOWN_ERRORS) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                     got.integer_value, got.fraction_q32, got.fraction_count, got.digit_seen);
         end
         error_count++;
      end else begin
         want = pending_numbers.pop_front();
         if (got.integer_value !== want.integer_value) begin
            report_mismatch("integer_value", want.integer_value, got.integer_value);
         end
         if (got.fraction_q32 !== want.fraction_q32) begin
            report_mismatch("fraction_q32", want.fraction_q32, got.fraction_q32);
         end
         if (got.fraction_count !== want.fraction_count) begin
            report_mismatch("fraction_count", 32'(want.fraction_count), 32'(got.fraction_count));
         end
         if (got.digit_seen !== want.digit_seen) begin
            report_mismatch("digit_seen", 32'(want.digit_seen), 32'(got.digit_seen));
         end
      end
   endfunction

   function automatic void queue_char(input logic [7:0] code, input logic last);
      req_type item;
      item.char_code = code;
      item.end_of_text = last;
      outgoing_chars.push_back(item);
      chars_queued++;
   endfunction

   function automatic void queue_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         queue_char(text[i], i == text.len() - 1);
      end
   endfunction

   // Any code that neither is a digit nor matches the separator.
   function automatic logic [7:0] junk_char();
      logic [7:0] code;
      do begin
         code = 8'($urandom_range(0, 255));
      end while ((code >= CHAR_ZERO && code <= CHAR_NINE) || code == separator_now);
      return code;
   endfunction

   // Waits until every character is sent and every number has come back.
   task automatic wait_until_drained();
      while (outgoing_chars.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (pending_numbers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request side: bursts of characters separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            parse_char(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (outgoing_chars.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= outgoing_chars.pop_front();
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: checks each number and paces ready, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_number(rsp_data);
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_cycles == 0) begin
               ready_pattern <= ready_pattern_type'($urandom_range(0, 3));
               pattern_cycles <= $urandom_range(16, 96);
            end else begin
               pattern_cycles <= pattern_cycles - 1;
            end
            case (ready_pattern)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= $urandom_range(0, 3) == 0;
               default:      rsp_ready <= $urandom_range(0, 3) != 0;
            endcase
         end
      end
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
      begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: one phase per separator setting, each drained before the next write.
   initial begin
      logic [7:0] text[$];
      int         n;
      int         target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            wait_until_drained();
            @(posedge clock);
            csr_write_enable <= 1'b1;
            csr_write_data <= separator_plan[p];
            @(posedge clock);
            csr_write_enable <= 1'b0;
            separator_now = separator_plan[p];
         end
         if (p == 0) begin
            // Extreme codes skipped, a leading separator, no digit at all, a repeated
            // separator, a stop character and too many fraction digits.
            queue_char(8'h00, 1'b0);
            queue_char(8'hFF, 1'b0);
            queue_char("7", 1'b1);
            queue_text(".5");
            queue_text("x");
            queue_text("1..9");
            queue_text("1a2");
            queue_text("0.9999999999");
         end
         if (separator_now >= CHAR_ZERO && separator_now <= CHAR_NINE) begin
            // A digit separator opens the fraction, then acts as a separator again.
            queue_char(separator_now, 1'b0);
            queue_char("1", 1'b0);
            queue_char(separator_now, 1'b1);
         end
         if (p == PRESSURE_PHASE) begin
            hold_request <= 1'b1;
         end
         target = chars_queued + PHASE_CHARS;
         while (chars_queued < target) begin
            text.delete();
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any code at all.
               n = $urandom_range(1, 6);
               repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end else begin
               // Leading junk, integer digits, separators, fraction digits, maybe a stop.
               repeat ($urandom_range(0, 2)) begin
                  text.push_back(($urandom_range(0, 3) == 0) ? separator_now : junk_char());
               end
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
               repeat (n) text.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
               if ($urandom_range(0, 3) != 0) begin
                  n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
                  repeat (n) text.push_back(separator_now);
                  n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(0, 5);
                  repeat (n) text.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
               end
               if ($urandom_range(0, 4) == 0) begin
                  text.push_back(junk_char());
                  repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
               end
            end
            if (text.size() == 0) begin
               text.push_back(junk_char());
            end
            foreach (text[i]) begin
               queue_char(text[i], i == text.size() - 1);
            end
         end
      end
      wait_until_drained();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
